>>> rtl/rmf_pkg.sv
// Package for the running median filter.
// Holds the window size, sample widths and the link type that the sorted cells share.
// No dependencies.
package rmf_pkg;

    // Window length and sample width of the filter.
    localparam int WINDOW      = 10;
    localparam int SAMPLE_BITS = 20;

    // Fixed port widths.
    localparam int IN_BITS  = 20;
    localparam int OUT_BITS = 21;

    // Age counter: an entry leaves the window when its age reaches WINDOW-1.
    localparam int AGE_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Cells that hold the middle sorted values. For an odd window both
    // point at the same cell, so their sum is twice the median.
    localparam int HI_IDX = WINDOW / 2;
    localparam int LO_IDX = ((WINDOW % 2) == 1) ? (WINDOW / 2) : (WINDOW / 2 - 1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [AGE_BITS-1:0]    t_age;
    typedef logic [SAMPLE_BITS:0]   t_sum;

    localparam t_age AGE_MAX = t_age'(WINDOW - 1);

    // What one cell shows its neighbors.
    typedef struct packed {
        t_sample value;   // stored sample
        t_age    age;     // items since it entered
        logic    gt;      // stored sample is greater than the incoming one
        logic    del_le;  // the aged-out entry sits in this cell or below
        logic    aged;    // this cell holds the aged-out entry
    } t_link;

endpackage

>>> rtl/rmf_cell.sv
// One cell of the sorted window: holds a sample and its age.
// On each item it takes its next content from itself, a neighbor or the new sample.
// Depends on rmf_pkg.
module rmf_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  rmf_pkg::t_sample i_sample,
    input  rmf_pkg::t_age  i_init_age,
    input  logic           i_is_bottom,
    input  logic           i_is_top,
    input  rmf_pkg::t_link i_lower,
    input  rmf_pkg::t_link i_upper,
    output rmf_pkg::t_link o_link
);
    import rmf_pkg::*;

    t_sample r_value, n_value;
    t_age    r_age,   n_age;

    logic    w_gt;
    logic    w_aged;
    logic    w_del_le;
    t_sample w_cur_value;
    t_age    w_cur_age;
    logic    w_cur_gt;
    t_sample w_prev_value;
    t_age    w_prev_age;
    logic    w_prev_gt;

    // Local compare and aged-out detection.
    assign w_gt     = (r_value > i_sample);
    assign w_aged   = (r_age == AGE_MAX);
    assign w_del_le = i_lower.del_le | w_aged;

    // Entry that lands at this position once the aged-out entry is removed.
    assign w_cur_value = w_del_le ? i_upper.value : r_value;
    assign w_cur_age   = w_del_le ? i_upper.age   : r_age;
    assign w_cur_gt    = w_del_le ? i_upper.gt    : w_gt;

    // Same for the position just below.
    assign w_prev_value = i_lower.del_le ? r_value : i_lower.value;
    assign w_prev_age   = i_lower.del_le ? r_age   : i_lower.age;
    assign w_prev_gt    = i_lower.del_le ? w_gt    : i_lower.gt;

    // Insert the new sample into the compacted sorted list.
    always_comb begin
        priority if (!i_is_top && !w_cur_gt) begin
            n_value = w_cur_value;
            n_age   = t_age'(w_cur_age + 1'b1);
        end else if (i_is_bottom || !w_prev_gt) begin
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_value = w_prev_value;
            n_age   = t_age'(w_prev_age + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_age   <= i_init_age;
        end else if (i_load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_link.value  = r_value;
    assign o_link.age    = r_age;
    assign o_link.gt     = w_gt;
    assign o_link.del_le = w_del_le;
    assign o_link.aged   = w_aged;

endmodule

>>> rtl/rmf_chain.sv
// Row of sorted cells that holds the whole window in ascending order.
// Gives the two middle values of the window.
// Depends on rmf_pkg and rmf_cell.
module rmf_chain (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rmf_pkg::t_sample i_sample,
    output rmf_pkg::t_sample o_lo,
    output rmf_pkg::t_sample o_hi
);
    import rmf_pkg::*;

    t_link w_link [WINDOW];
    logic [WINDOW-1:0] w_aged;
    logic [WINDOW-1:0] w_fresh;
    logic [WINDOW-1:0] w_order;

    // Cells wired to their neighbors; the ends see an empty link.
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        t_link w_lower;
        t_link w_upper;

        if (g == 0) begin : g_lo_end
            assign w_lower = '0;
        end else begin : g_lo_nb
            assign w_lower = w_link[g-1];
        end

        if (g == WINDOW - 1) begin : g_hi_end
            assign w_upper    = '0;
            assign w_order[g] = 1'b1;
        end else begin : g_hi_nb
            assign w_upper    = w_link[g+1];
            assign w_order[g] = (w_link[g].value <= w_link[g+1].value);
        end

        assign w_aged[g]  = w_link[g].aged;
        assign w_fresh[g] = (w_link[g].age == '0);

        rmf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (i_load),
            .i_sample    (i_sample),
            .i_init_age  (t_age'(WINDOW - 1 - g)),
            .i_is_bottom (g == 0),
            .i_is_top    (g == WINDOW - 1),
            .i_lower     (w_lower),
            .i_upper     (w_upper),
            .o_link      (w_link[g])
        );
    end

    // Middle taps of the sorted row.
    assign o_lo = w_link[LO_IDX].value;
    assign o_hi = w_link[HI_IDX].value;

`ifndef SYNTHESIS
    a_one_aged : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_aged))
        else $error("window does not hold exactly one aged-out entry");

    a_one_fresh : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_fresh))
        else $error("window does not hold exactly one newest entry");

    a_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_order))
        else $error("cell row is out of ascending order");
`endif

endmodule

>>> rtl/running_median_filter.sv
// Channel   | Direction | Valid    | Stall    | Payload
// input     | in        | i_valid  | o_stall  | i_sample (20 bits)
// result    | out       | o_valid  | i_stall  | o_median_doubled (21 bits)
//
// Sustains one item per cycle while i_stall is low. Each item updates the sorted cell row
// as it is accepted; the two middle cells are then added into the output register once
// it can take them, and o_valid rises as that sum is registered.
// Reset (synchronous) clears the window to zeros and empties both stages.
// A stall on the result side holds a full output register; a pending median then stays
// in the median stage and o_stall is raised in the same cycle.
// Top level of the running median filter; depends on rmf_pkg and rmf_chain.
module running_median_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [rmf_pkg::IN_BITS-1:0]  i_sample,
    output logic                         o_stall,
    output logic                         o_valid,
    output logic [rmf_pkg::OUT_BITS-1:0] o_median_doubled,
    input  logic                         i_stall
);
    import rmf_pkg::*;

    logic                r_mv, n_mv;
    logic                r_ov, n_ov;
    logic [OUT_BITS-1:0] r_out;

    logic    w_acc;
    logic    w_move;
    t_sample w_lo;
    t_sample w_hi;
    t_sum    w_sum;

    // Handshake: the median stage drains when the output register is empty or not stalled.
    assign w_move  = r_mv && (!r_ov || !i_stall);
    assign o_stall = r_mv && !w_move;
    assign w_acc   = i_valid && !o_stall;

    rmf_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_acc),
        .i_sample (SAMPLE_BITS'(i_sample)),
        .o_lo     (w_lo),
        .o_hi     (w_hi)
    );

    // Sum of the two middle values is twice the median.
    assign w_sum = t_sum'({1'b0, w_lo}) + t_sum'({1'b0, w_hi});

    // Stage occupancy.
    always_comb begin
        n_mv = r_mv;
        if (w_acc) begin
            n_mv = 1'b1;
        end else if (w_move) begin
            n_mv = 1'b0;
        end
        n_ov = r_ov;
        if (w_move) begin
            n_ov = 1'b1;
        end else if (!i_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_mv <= n_mv;
            r_ov <= n_ov;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= OUT_BITS'(w_sum);
        end
    end

    assign o_valid          = r_ov;
    assign o_median_doubled = r_out;

`ifndef SYNTHESIS
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> (!r_mv || w_move))
        else $error("item accepted over a median not yet moved out");

    a_move_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> o_valid)
        else $error("moved median not presented at the output");

    a_accept_pends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_mv)
        else $error("accepted item left no pending median");
`endif

endmodule
